/* rtl/idb_pkg.sv */
// ----------------------------------------------------------------------------
// idb_pkg
// Shared widths, codes and types for the decimating IIR filter and its
// digit-serial multiply-accumulate unit.
// ----------------------------------------------------------------------------
package idb_pkg;

    // Field and register widths.
    localparam int SAMPLE_W  = 24;
    localparam int COEF_W    = 24;
    localparam int NUM_REGS  = 8;
    localparam int REG_IDX_W = 3;
    localparam int MAX_TAPS  = 4;
    localparam int K_W       = 2;

    // Digit-serial multiplier geometry: the coefficient is consumed four bits
    // per cycle, least significant digit first; the top digit is signed.
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = COEF_W / DIGIT_W;
    localparam int DCNT_W     = 3;
    localparam int X_W        = SAMPLE_W + 1;
    localparam int DPROD_W    = X_W + DIGIT_W + 1;
    localparam int PP_LO_W    = COEF_W - DIGIT_W;
    localparam int PROD_W     = DPROD_W + PP_LO_W;
    localparam int ACC_W      = 52;

    // Q.43 sum to Q.23 output: round half up, then floor.
    localparam int FRAC_SHIFT = 20;
    localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(64'd1 << (FRAC_SHIFT - 1));

    // Upper bit of the register index selects the coefficient bank.
    localparam logic PHASE_FEED = 1'b0;
    localparam logic PHASE_BACK = 1'b1;

    typedef struct packed {
        logic clear;   // preset the accumulator to the rounding bias
        logic load;    // take a new operand pair and start a product
    } mac_ctl_t;

endpackage

/* rtl/idb_mac.sv */
// ----------------------------------------------------------------------------
// idb_mac
// Digit-serial multiply-accumulate: one signed 25-bit operand times one signed
// 24-bit coefficient, four coefficient bits per cycle, summed into a wide
// accumulator when the last digit is done.
// ----------------------------------------------------------------------------
module idb_mac (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  idb_pkg::mac_ctl_t                      ctl,
    input  logic signed [idb_pkg::X_W-1:0]         x,
    input  logic        [idb_pkg::COEF_W-1:0]      coef,
    output logic                                   done,
    output logic signed [idb_pkg::ACC_W-1:0]       acc
);

    localparam logic [idb_pkg::DCNT_W-1:0] LAST_DIGIT =
        idb_pkg::DCNT_W'(idb_pkg::NUM_DIGITS - 1);

    logic                                  busy_reg;
    logic [idb_pkg::DCNT_W-1:0]            dcnt_reg;
    logic signed [idb_pkg::X_W-1:0]        x_reg;
    logic [idb_pkg::COEF_W-1:0]            coef_sh_reg;
    logic signed [idb_pkg::DPROD_W-1:0]    pp_hi_reg;
    logic [idb_pkg::PP_LO_W-1:0]           pp_lo_reg;
    logic signed [idb_pkg::ACC_W-1:0]      acc_reg;

    logic                                  last_digit;
    logic signed [idb_pkg::DIGIT_W:0]      digit;
    logic signed [idb_pkg::DPROD_W-1:0]    dprod;
    logic signed [idb_pkg::DPROD_W-1:0]    pp_sum;
    logic [idb_pkg::ACC_W-1:0]             prod_ext;

    assign last_digit = (dcnt_reg == LAST_DIGIT);

    // All digits are unsigned except the top one, which carries the sign.
    assign digit = last_digit
        ? {coef_sh_reg[idb_pkg::DIGIT_W-1], coef_sh_reg[idb_pkg::DIGIT_W-1:0]}
        : {1'b0, coef_sh_reg[idb_pkg::DIGIT_W-1:0]};

    assign dprod  = digit * x_reg;
    assign pp_sum = pp_hi_reg + dprod;

    // Full product is pp_sum weighted by 2^20 over the twenty bits shifted out.
    assign prod_ext = {{(idb_pkg::ACC_W - idb_pkg::PROD_W){pp_sum[idb_pkg::DPROD_W-1]}},
                       pp_sum, pp_lo_reg};

    assign done = busy_reg && last_digit;
    assign acc  = acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            dcnt_reg <= '0;
        end else if (ctl.load) begin
            busy_reg <= 1'b1;
            dcnt_reg <= '0;
        end else if (busy_reg) begin
            if (last_digit) begin
                busy_reg <= 1'b0;
            end
            dcnt_reg <= dcnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            x_reg       <= x;
            coef_sh_reg <= coef;
            pp_hi_reg   <= '0;
        end else if (busy_reg) begin
            coef_sh_reg <= coef_sh_reg >> idb_pkg::DIGIT_W;
            pp_hi_reg   <= pp_sum >>> idb_pkg::DIGIT_W;
            pp_lo_reg   <= {pp_sum[idb_pkg::DIGIT_W-1:0],
                            pp_lo_reg[idb_pkg::PP_LO_W-1:idb_pkg::DIGIT_W]};
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.clear) begin
            acc_reg <= idb_pkg::ROUND_BIAS;
        end else if (done) begin
            acc_reg <= acc_reg + prod_ext;
        end
    end

endmodule

/* rtl/iir_decimate_by_two.sv */
// Each of the 2*TAPS products of a sample takes a load step and then one pass over the digits
// in the 4-bit digit-serial multiplier; no new item is taken before the last one's result is out.
// A finished result waits in the output register while the next item is taken in.
// Reset (aresetn low, synchronous) zeroes coefficients and both histories and
// empties the output register.
// ----------------------------------------------------------------------------
// iir_decimate_by_two
// Two-times decimating direct-form IIR filter with one shared digit-serial MAC.
// ----------------------------------------------------------------------------
module iir_decimate_by_two #(
    parameter int TAPS = 4
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [idb_pkg::SAMPLE_W-1:0]    s_sample_first,
    input  logic signed [idb_pkg::SAMPLE_W-1:0]    s_sample_second,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [idb_pkg::SAMPLE_W-1:0]    m_decimated_sample,
    input  logic                                   cfg_wr_en,
    input  logic [idb_pkg::REG_IDX_W-1:0]          cfg_index,
    input  logic [idb_pkg::COEF_W-1:0]             cfg_data
);

    localparam int HW   = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int KL   = TAPS - 1;
    localparam logic [idb_pkg::K_W-1:0] K_LAST = KL[idb_pkg::K_W-1:0];
    localparam int SW   = idb_pkg::SAMPLE_W;
    localparam int QTOP = idb_pkg::FRAC_SHIFT + SW - 1;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SHIFT = 5'b00010,
        ST_LOAD  = 5'b00100,
        ST_WAIT  = 5'b01000,
        ST_ROUND = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [idb_pkg::COEF_W-1:0]   coef_reg [idb_pkg::NUM_REGS];
    logic signed [SW-1:0]         in_hist_reg  [TAPS];
    logic signed [SW-1:0]         out_hist_reg [TAPS];
    logic signed [SW-1:0]         samp1_reg, samp2_reg;
    logic                         second_reg, second_next;
    logic                         phase_reg, phase_next;
    logic [idb_pkg::K_W-1:0]      k_reg, k_next;
    logic                         m_valid_reg, m_valid_next;
    logic signed [SW-1:0]         m_data_reg;

    idb_pkg::mac_ctl_t                   mac_ctl;
    logic                                mac_done;
    logic signed [idb_pkg::ACC_W-1:0]    mac_acc;

    logic [HW-1:0]                       hidx;
    logic signed [SW-1:0]                op_hist;
    logic signed [idb_pkg::X_W-1:0]      op_ext;
    logic signed [idb_pkg::X_W-1:0]      mac_x;
    logic signed [SW-1:0]                cur_sample;
    logic signed [SW-1:0]                q_sat;
    logic                                q_fits;
    logic                                out_free;
    logic                                do_shift;
    logic                                do_commit;
    logic                                do_emit;

    // ------------------------------------------------------------------
    // Operand selection for the current term.
    // ------------------------------------------------------------------
    assign hidx       = k_reg[HW-1:0];
    assign op_hist    = (phase_reg == idb_pkg::PHASE_BACK) ? out_hist_reg[hidx]
                                                           : in_hist_reg[hidx];
    assign op_ext     = {op_hist[SW-1], op_hist};
    // Feedback terms are subtracted, so the operand goes in negated.
    assign mac_x      = (phase_reg == idb_pkg::PHASE_BACK) ? -op_ext : op_ext;
    assign cur_sample = second_reg ? samp2_reg : samp1_reg;

    idb_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mac_ctl),
        .x       (mac_x),
        .coef    (coef_reg[{phase_reg, k_reg}]),
        .done    (mac_done),
        .acc     (mac_acc)
    );

    // The accumulator already holds the rounding bias, so the rounded value is
    // a plain slice; it fits 24 bits when its sign bit and all bits above it agree.
    assign q_fits = (mac_acc[idb_pkg::ACC_W-1:QTOP] == '0) ||
                    (mac_acc[idb_pkg::ACC_W-1:QTOP] == '1);
    assign q_sat  = q_fits ? mac_acc[QTOP:idb_pkg::FRAC_SHIFT]
                  : (mac_acc[idb_pkg::ACC_W-1] ? {1'b1, {(SW-1){1'b0}}}
                                               : {1'b0, {(SW-1){1'b1}}});

    assign out_free = !m_valid_reg || m_ready;

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb begin
        state_next   = state_reg;
        second_next  = second_reg;
        phase_next   = phase_reg;
        k_next       = k_reg;
        m_valid_next = m_valid_reg && !m_ready;
        mac_ctl      = '0;
        do_shift     = 1'b0;
        do_commit    = 1'b0;
        do_emit      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    second_next = 1'b0;
                    state_next  = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                do_shift      = 1'b1;
                mac_ctl.clear = 1'b1;
                phase_next    = idb_pkg::PHASE_FEED;
                k_next        = '0;
                state_next    = ST_LOAD;
            end
            ST_LOAD: begin
                mac_ctl.load = 1'b1;
                state_next   = ST_WAIT;
            end
            ST_WAIT: begin
                if (mac_done) begin
                    if (k_reg != K_LAST) begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_LOAD;
                    end else if (phase_reg == idb_pkg::PHASE_FEED) begin
                        phase_next = idb_pkg::PHASE_BACK;
                        k_next     = '0;
                        state_next = ST_LOAD;
                    end else begin
                        state_next = ST_ROUND;
                    end
                end
            end
            ST_ROUND: begin
                if (!second_reg) begin
                    do_commit   = 1'b1;
                    second_next = 1'b1;
                    state_next  = ST_SHIFT;
                end else if (out_free) begin
                    do_commit    = 1'b1;
                    do_emit      = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            second_reg  <= 1'b0;
            phase_reg   <= idb_pkg::PHASE_FEED;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            second_reg  <= second_next;
            phase_reg   <= phase_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            samp1_reg <= s_sample_first;
            samp2_reg <= s_sample_second;
        end
        if (do_emit) begin
            m_data_reg <= q_sat;
        end
    end

    // Coefficient bank.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < idb_pkg::NUM_REGS; i++) begin
                coef_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            coef_reg[cfg_index] <= cfg_data;
        end
    end

    // Histories: both shift by one slot per sample; output slot 0 keeps the
    // previous output until the new one is rounded.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TAPS; i++) begin
                in_hist_reg[i]  <= '0;
                out_hist_reg[i] <= '0;
            end
        end else begin
            if (do_shift) begin
                for (int i = TAPS - 1; i > 0; i--) begin
                    in_hist_reg[i]  <= in_hist_reg[i-1];
                    out_hist_reg[i] <= out_hist_reg[i-1];
                end
                in_hist_reg[0] <= cur_sample;
            end
            if (do_commit) begin
                out_hist_reg[0] <= q_sat;
            end
        end
    end

    assign s_ready            = (state_reg == ST_IDLE);
    assign m_valid            = m_valid_reg;
    assign m_decimated_sample = m_data_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mac_done |-> (state_reg == ST_WAIT))
        else $error("MAC finished a product outside the wait state");

    a_result_from_round: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_ROUND && second_reg))
        else $error("result register loaded without a finished second sample");

    a_hold_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND && second_reg && m_valid_reg && !m_ready)
        |=> (state_reg == ST_ROUND))
        else $error("pending result would have been overwritten");

    a_k_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (k_reg <= K_LAST))
        else $error("tap counter beyond the last tap");

endmodule
